[rtl/lpic_pkg.sv]
// ----------------------------------------------------------------------------
// Local plane inlier counter package
// Shared widths, the configuration bundle and the item layout constants.
// ----------------------------------------------------------------------------
package lpic_pkg;

  localparam int unsigned CNT_W      = 17;
  localparam int unsigned CENTER_W   = 48;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned RAD_W      = 16;
  localparam int unsigned APB_ADDR_W = 6;
  localparam int unsigned APB_DATA_W = 64;

  // Queue between the front and the back part.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Classification bits carried with each queued point:
  // three 16-bit distance magnitudes, the far flag and the last flag.
  localparam int unsigned CLASS_W = 3 * RAD_W + 2;

  typedef struct packed {
    logic signed [NORM_W-1:0]   normal_x;
    logic signed [NORM_W-1:0]   normal_y;
    logic signed [NORM_W-1:0]   normal_z;
    logic signed [OFFSET_W-1:0] plane_offset;
    logic [CENTER_W-1:0]        center_xyz;
    logic [RAD_W-1:0]           radius;
    logic [RAD_W-1:0]           threshold;
    logic                       update_en;
  } cfg_t;

endpackage

[rtl/lpic_cfg.sv]
// ----------------------------------------------------------------------------
// Local plane inlier counter configuration registers
// APB register file holding the plane hypothesis and the tracking enable.
// ----------------------------------------------------------------------------
module lpic_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lpic_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lpic_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lpic_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output lpic_pkg::cfg_t                     cfg_o,
  output logic                               clear_best_o
);
  import lpic_pkg::*;

  typedef enum logic [2:0] {
    RegNormalX  = 3'd0,
    RegNormalY  = 3'd1,
    RegNormalZ  = 3'd2,
    RegOffset   = 3'd3,
    RegCenter   = 3'd4,
    RegRadius   = 3'd5,
    RegThresh   = 3'd6,
    RegUpdateEn = 3'd7
  } reg_idx_e;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready       = 1'b1;
  assign idx          = reg_idx_e'(paddr[5:3]);
  assign wr_en        = psel & penable & pwrite & pready;
  // Any register write restarts the best-count record.
  assign clear_best_o = wr_en;
  assign cfg_o        = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegNormalX:  cfg_d.normal_x     = pwdata[NORM_W-1:0];
        RegNormalY:  cfg_d.normal_y     = pwdata[NORM_W-1:0];
        RegNormalZ:  cfg_d.normal_z     = pwdata[NORM_W-1:0];
        RegOffset:   cfg_d.plane_offset = pwdata[OFFSET_W-1:0];
        RegCenter:   cfg_d.center_xyz   = pwdata[CENTER_W-1:0];
        RegRadius:   cfg_d.radius       = pwdata[RAD_W-1:0];
        RegThresh:   cfg_d.threshold    = pwdata[RAD_W-1:0];
        RegUpdateEn: cfg_d.update_en    = pwdata[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegNormalX:  prdata = APB_DATA_W'($unsigned(cfg_q.normal_x));
      RegNormalY:  prdata = APB_DATA_W'($unsigned(cfg_q.normal_y));
      RegNormalZ:  prdata = APB_DATA_W'($unsigned(cfg_q.normal_z));
      RegOffset:   prdata = APB_DATA_W'($unsigned(cfg_q.plane_offset));
      RegCenter:   prdata = APB_DATA_W'(cfg_q.center_xyz);
      RegRadius:   prdata = APB_DATA_W'(cfg_q.radius);
      RegThresh:   prdata = APB_DATA_W'(cfg_q.threshold);
      RegUpdateEn: prdata = APB_DATA_W'(cfg_q.update_en);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{normal_x: '0, normal_y: '0, normal_z: 16'sd16384,
                 plane_offset: '0, center_xyz: '0, radius: '0,
                 threshold: '0, update_en: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/lpic_fifo.sv]
// ----------------------------------------------------------------------------
// Local plane inlier counter queue
// Small first-in first-out buffer between the front and the back part.
// ----------------------------------------------------------------------------
module lpic_fifo #(
  parameter int unsigned DATA_W = 98
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);
  import lpic_pkg::*;

  logic [DATA_W-1:0]     mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/lpic_front.sv]
// ----------------------------------------------------------------------------
// Local plane inlier counter front part
// Accepts points, measures per-axis distance to the center and queues them.
// ----------------------------------------------------------------------------
module lpic_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  logic signed [COORD_BITS-1:0]                 point_x_i,
  input  logic signed [COORD_BITS-1:0]                 point_y_i,
  input  logic signed [COORD_BITS-1:0]                 point_z_i,
  input  logic                                         last_point_i,
  input  lpic_pkg::cfg_t                               cfg_i,
  input  logic                                         q_pop_i,
  output logic                                         q_valid_o,
  output logic [3*COORD_BITS+lpic_pkg::CLASS_W-1:0]    q_data_o
);
  import lpic_pkg::*;

  localparam int unsigned ItemW = 3 * COORD_BITS + CLASS_W;
  localparam int unsigned DiffW = ((COORD_BITS > RAD_W) ? COORD_BITS : RAD_W) + 1;

  logic signed [COORD_BITS-1:0] pt   [3];
  logic signed [RAD_W-1:0]      ctr  [3];
  logic signed [DiffW-1:0]      diff [3];
  logic [DiffW-1:0]             mag  [3];
  logic [2:0]                   far_ax;
  logic [ItemW-1:0]             item;
  logic                         full;

  assign pt[0]  = point_x_i;
  assign pt[1]  = point_y_i;
  assign pt[2]  = point_z_i;
  assign ctr[0] = cfg_i.center_xyz[15:0];
  assign ctr[1] = cfg_i.center_xyz[31:16];
  assign ctr[2] = cfg_i.center_xyz[47:32];

  // A point farther than the radius along any axis is an outlier; this also
  // keeps the squared distances within 16-bit magnitudes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]   = DiffW'(pt[i]) - DiffW'(ctr[i]);
      mag[i]    = diff[i][DiffW-1] ? DiffW'(-diff[i]) : DiffW'(diff[i]);
      far_ax[i] = mag[i] > DiffW'(cfg_i.radius);
    end
  end

  assign item = {point_x_i, point_y_i, point_z_i, last_point_i, |far_ax,
                 mag[0][RAD_W-1:0], mag[1][RAD_W-1:0], mag[2][RAD_W-1:0]};

  assign in_stall_o = full;

  lpic_fifo #(
    .DATA_W(ItemW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .data_i (item),
    .full_o (full),
    .pop_i  (q_pop_i),
    .valid_o(q_valid_o),
    .data_o (q_data_o)
  );

endmodule

[rtl/lpic_back.sv]
// ----------------------------------------------------------------------------
// Local plane inlier counter back part
// Plane distance and radius tests, pass counting, best tracking and output.
// ----------------------------------------------------------------------------
module lpic_back #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  lpic_pkg::cfg_t                               cfg_i,
  input  logic                                         clear_best_i,
  input  logic                                         q_valid_i,
  input  logic [3*COORD_BITS+lpic_pkg::CLASS_W-1:0]    q_data_i,
  output logic                                         q_pop_o,
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output logic [lpic_pkg::CNT_W-1:0]                   inlier_count_o,
  output logic [lpic_pkg::CNT_W-1:0]                   best_count_o,
  output logic [lpic_pkg::CENTER_W-1:0]                best_center_o,
  output logic                                         best_changed_o
);
  import lpic_pkg::*;

  localparam int unsigned ProdW = NORM_W + COORD_BITS;
  localparam int unsigned DotW  = ((ProdW > OFFSET_W) ? ProdW : OFFSET_W) + 2;
  localparam int unsigned SqW   = 2 * RAD_W;
  localparam int unsigned SumW  = SqW + 2;
  localparam int unsigned CapI  = (MAX_POINTS < 131071) ? MAX_POINTS : 131071;
  localparam logic [CNT_W-1:0] CountCap = CNT_W'(CapI);

  // Unpacked queue head.
  logic signed [COORD_BITS-1:0] pt  [3];
  logic signed [NORM_W-1:0]     nrm [3];
  logic [RAD_W-1:0]             dmag [3];
  logic                         q_far;
  logic                         q_last;

  // Stage 1: products and distance magnitudes.
  logic                         s1_valid_q;
  logic                         s1_last_q;
  logic                         s1_far_q;
  logic signed [ProdW-1:0]      prod_q [3];
  logic [RAD_W-1:0]             dmag_q [3];

  // Stage 2: plane test result and squared distances.
  logic                         s2_valid_q;
  logic                         s2_last_q;
  logic                         s2_far_q;
  logic                         s2_plane_ok_q;
  logic [SqW-1:0]               sq_q [3];

  logic signed [DotW-1:0]       dot;
  logic [DotW-1:0]              adot;
  logic [SumW-1:0]              sum_sq;
  logic [SqW-1:0]               rad_sq_q;
  logic                         inlier;
  logic                         adv;

  logic [CNT_W-1:0]             run_q;
  logic [CNT_W-1:0]             run_next;
  logic [CNT_W-1:0]             best_q;
  logic [CENTER_W-1:0]          best_center_q;
  logic                         out_valid_q;
  logic                         beats_best;

  assign pt[0]   = q_data_i[CLASS_W+2*COORD_BITS +: COORD_BITS];
  assign pt[1]   = q_data_i[CLASS_W+COORD_BITS +: COORD_BITS];
  assign pt[2]   = q_data_i[CLASS_W +: COORD_BITS];
  assign q_last  = q_data_i[CLASS_W-1];
  assign q_far   = q_data_i[CLASS_W-2];
  assign dmag[0] = q_data_i[2*RAD_W +: RAD_W];
  assign dmag[1] = q_data_i[RAD_W +: RAD_W];
  assign dmag[2] = q_data_i[0 +: RAD_W];
  assign nrm[0]  = cfg_i.normal_x;
  assign nrm[1]  = cfg_i.normal_y;
  assign nrm[2]  = cfg_i.normal_z;

  // The whole pipeline moves together; it only halts while a result is held.
  assign adv     = ~(out_valid_q & out_stall_i);
  assign q_pop_o = adv & q_valid_i;

  always_ff @(posedge clk_i) begin
    rad_sq_q <= SqW'(cfg_i.radius) * SqW'(cfg_i.radius);
    if (adv) begin
      s1_last_q <= q_last;
      s1_far_q  <= q_far;
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= ProdW'(nrm[i]) * ProdW'(pt[i]);
        dmag_q[i] <= dmag[i];
      end
      s2_last_q     <= s1_last_q;
      s2_far_q      <= s1_far_q;
      s2_plane_ok_q <= adot <= DotW'({cfg_i.threshold, 14'b0});
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SqW'(dmag_q[i]) * SqW'(dmag_q[i]);
      end
    end
  end

  always_comb begin
    dot  = DotW'(prod_q[0]) + DotW'(prod_q[1]) + DotW'(prod_q[2]) +
           DotW'(cfg_i.plane_offset);
    adot = dot[DotW-1] ? DotW'(-dot) : DotW'(dot);
  end

  assign sum_sq = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
  assign inlier = s2_plane_ok_q & ~s2_far_q & (cfg_i.radius != '0) &
                  (sum_sq <= SumW'(rad_sq_q));

  assign run_next   = (inlier && (run_q < CountCap)) ? run_q + 1'b1 : run_q;
  assign beats_best = cfg_i.update_en & (run_next > best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      run_q         <= '0;
      best_q        <= '0;
      best_center_q <= '0;
    end else begin
      if (adv) begin
        s1_valid_q <= q_valid_i;
        s2_valid_q <= s1_valid_q;
      end
      if (adv && s2_valid_q && s2_last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (adv && s2_valid_q) begin
        run_q <= s2_last_q ? '0 : run_next;
      end
      if (clear_best_i) begin
        best_q <= '0;
      end else if (adv && s2_valid_q && s2_last_q && beats_best) begin
        best_q <= run_next;
        if (best_q != '0) begin
          best_center_q <= cfg_i.center_xyz;
        end
      end
    end
  end

  // Result register; loaded only when the final point of a pass retires.
  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q && s2_last_q) begin
      inlier_count_o <= run_next;
      best_changed_o <= beats_best;
      best_count_o   <= beats_best ? run_next : best_q;
      best_center_o  <= (beats_best && (best_q != '0)) ? cfg_i.center_xyz
                                                         : best_center_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/local_plane_inlier_counter_core.sv]
// ----------------------------------------------------------------------------
// Local plane inlier counter
// Counts the points of a pass that lie near a local plane hypothesis.
// ----------------------------------------------------------------------------
// Points arrive on the input channel (in_valid_i / in_stall_o); a transfer
// takes place at a clock edge with valid high and stall low. The final point
// of a pass carries last_point_i. Only that point produces a result transfer
// on the output channel (out_valid_o / out_stall_i): the pass inlier count,
// the best count so far, the recorded best center and a flag that tells
// whether this pass became the new best.
// The block accepts one point per cycle while its input queue is not full. A
// result passes from the input queue through the two register stages of the
// multiply-and-compare pipeline into the result register. When the receiver
// stalls, the result is held and the pipeline freezes, while the four-entry
// input queue keeps taking points until it is full.
// Reset clears the queue, the pipeline, the running count and the best
// record, and loads the register defaults (normal along z, tracking on).
// The user configures the plane through the APB port only while no pass is
// in flight; the block does not enforce it. Every write clears the best count.
// ----------------------------------------------------------------------------
module local_plane_inlier_counter_core #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lpic_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [lpic_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [lpic_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,

  // Point channel.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [COORD_BITS-1:0]         point_x_i,
  input  logic signed [COORD_BITS-1:0]         point_y_i,
  input  logic signed [COORD_BITS-1:0]         point_z_i,
  input  logic                                 last_point_i,

  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lpic_pkg::CNT_W-1:0]           inlier_count_o,
  output logic [lpic_pkg::CNT_W-1:0]           best_count_o,
  output logic [lpic_pkg::CENTER_W-1:0]        best_center_o,
  output logic                                 best_changed_o
);
  import lpic_pkg::*;

  localparam int unsigned ItemW = 3 * COORD_BITS + CLASS_W;

  cfg_t             cfg;
  logic             clear_best;
  logic             q_valid;
  logic             q_pop;
  logic [ItemW-1:0] q_data;

  // Register file for the plane hypothesis.
  lpic_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .clear_best_o(clear_best)
  );

  // The front part measures each point against the center and queues it, so
  // that point transfers continue while the back part waits on the receiver.
  lpic_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .last_point_i(last_point_i),
    .cfg_i       (cfg),
    .q_pop_i     (q_pop),
    .q_valid_o   (q_valid),
    .q_data_o    (q_data)
  );

  // The back part runs the plane and radius tests, counts inliers and keeps
  // the winner-take-all record.
  lpic_back #(
    .COORD_BITS(COORD_BITS),
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .clear_best_i  (clear_best),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .inlier_count_o(inlier_count_o),
    .best_count_o  (best_count_o),
    .best_center_o (best_center_o),
    .best_changed_o(best_changed_o)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Local plane inlier counter testbench
// Streams point passes into the core, predicts every pass report on the side
// and compares each report transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import lpic_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int COORD_BITS     = 16;
  localparam int MAX_POINTS     = 65536;
  localparam int REG_STRIDE     = 8;      // 64-bit data bus, so registers sit 8 bytes apart
  localparam int SETTLE_CYCLES  = 8;      // lets the core run dry after the last owed report
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1700;

  // The running count sticks at the smaller of the point limit and the 17-bit ceiling.
  localparam logic [CNT_W-1:0] COUNT_CAP =
    CNT_W'((MAX_POINTS < 131071) ? MAX_POINTS : 131071);

  typedef enum int unsigned {
    REG_NORMAL_X,
    REG_NORMAL_Y,
    REG_NORMAL_Z,
    REG_PLANE_OFFSET,
    REG_CENTER_XYZ,
    REG_RADIUS,
    REG_THRESHOLD,
    REG_UPDATE_EN
  } reg_idx_e;

  typedef enum logic {
    STEP_WRITE,
    STEP_POINT
  } step_kind_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         last;
  } point_t;

  typedef struct packed {
    logic [CNT_W-1:0]    inlier_count;
    logic [CNT_W-1:0]    best_count;
    logic [CENTER_W-1:0] best_center;
    logic                best_changed;
  } report_t;

  // One row of the directed plan: either a register write or a point. A point
  // row may carry a report typed in by hand, used instead of the prediction.
  typedef struct packed {
    step_kind_e  kind;
    reg_idx_e    idx;
    logic [63:0] value;
    point_t      pt;
    logic        fixed;
    report_t     want;
  } plan_step_t;

  // Clock and reset.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Every input of the core starts at a known value.
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0]         paddr   = '0;
  logic [APB_DATA_W-1:0]         pwdata  = '0;
  logic [APB_DATA_W-1:0]         prdata;
  logic                          pready;

  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic signed [COORD_BITS-1:0]  point_x    = '0;
  logic signed [COORD_BITS-1:0]  point_y    = '0;
  logic signed [COORD_BITS-1:0]  point_z    = '0;
  logic                          last_point = 1'b0;

  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic [CNT_W-1:0]              inlier_count;
  logic [CNT_W-1:0]              best_count;
  logic [CENTER_W-1:0]           best_center;
  logic                          best_changed;

  local_plane_inlier_counter_core #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .point_z_i      (point_z),
    .last_point_i   (last_point),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .inlier_count_o (inlier_count),
    .best_count_o   (best_count),
    .best_center_o  (best_center),
    .best_changed_o (best_changed)
  );

  // Shadow copy of the core: the plane registers, the count of the pass in
  // progress and the winner-take-all record. It starts at the reset values.
  cfg_t                plane_cfg = '{normal_x: '0, normal_y: '0, normal_z: 16'sd16384,
                                     plane_offset: '0, center_xyz: '0, radius: '0,
                                     threshold: '0, update_en: 1'b1};
  logic [CNT_W-1:0]    pass_tally    = '0;
  logic [CNT_W-1:0]    best_tally    = '0;
  logic [CENTER_W-1:0] best_center_q = '0;

  // Reports still owed by the core, oldest first.
  report_t awaited_reports[$];

  int mismatch_cnt = 0;

  // Sender pacing: bursts of transfers separated by idle gaps, unless a phase
  // asks for back-to-back traffic.
  int burst_left = 0;
  bit gapless    = 1'b0;

  // The main sequence asks for a long receiver hold-off by bumping this count;
  // the receiver process serves each request on its own.
  int holds_asked  = 0;
  int holds_served = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Counts one point against the current plane and returns 1 with the pass
  // report when the point closes a pass. The distance test runs on 64-bit
  // integers, wide enough that no product or sum can wrap.
  function automatic bit tally_point(input point_t p, output report_t rep);
    longint px, py, pz, nx, ny, nz, cx, cy, cz;
    longint dot, thr, rad, dx, dy, dz;
    bit     hit;
    px  = longint'(p.x);
    py  = longint'(p.y);
    pz  = longint'(p.z);
    nx  = longint'($signed(plane_cfg.normal_x));
    ny  = longint'($signed(plane_cfg.normal_y));
    nz  = longint'($signed(plane_cfg.normal_z));
    cx  = longint'($signed(plane_cfg.center_xyz[15:0]));
    cy  = longint'($signed(plane_cfg.center_xyz[31:16]));
    cz  = longint'($signed(plane_cfg.center_xyz[47:32]));
    rad = longint'(plane_cfg.radius);
    thr = longint'(plane_cfg.threshold) << 14;
    dot = nx * px + ny * py + nz * pz + longint'($signed(plane_cfg.plane_offset));
    if (dot < 0) dot = -dot;
    dx = (px >= cx) ? px - cx : cx - px;
    dy = (py >= cy) ? py - cy : cy - py;
    dz = (pz >= cz) ? pz - cz : cz - pz;
    // A zero radius marks the model invalid. The per-axis compare rejects far
    // points before the squares are summed.
    hit = (rad != 0) && (dot <= thr) && (dx <= rad) && (dy <= rad) && (dz <= rad) &&
          (dx * dx + dy * dy + dz * dz <= rad * rad);
    if (hit && pass_tally < COUNT_CAP) pass_tally = pass_tally + 1'b1;
    rep = '0;
    if (!p.last) return 1'b0;
    if (plane_cfg.update_en && pass_tally > best_tally) begin
      // The center is taken over only when a nonzero best is being beaten.
      if (best_tally != '0) best_center_q = plane_cfg.center_xyz;
      best_tally       = pass_tally;
      rep.best_changed = 1'b1;
    end
    rep.inlier_count = pass_tally;
    rep.best_count   = best_tally;
    rep.best_center  = best_center_q;
    pass_tally       = '0;
    return 1'b1;
  endfunction

  function automatic logic [CENTER_W-1:0] pack_center(input int cx, input int cy, input int cz);
    return {16'(cz), 16'(cy), 16'(cx)};
  endfunction

  function automatic plan_step_t write_row(input reg_idx_e idx, input logic [63:0] v);
    plan_step_t s;
    s       = '0;
    s.kind  = STEP_WRITE;
    s.idx   = idx;
    s.value = v;
    return s;
  endfunction

  function automatic plan_step_t point_row(input int x, input int y, input int z,
                                           input bit last);
    plan_step_t s;
    s         = '0;
    s.kind    = STEP_POINT;
    s.pt.x    = COORD_BITS'(x);
    s.pt.y    = COORD_BITS'(y);
    s.pt.z    = COORD_BITS'(z);
    s.pt.last = last;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // APB write: a setup cycle, then an access cycle that completes at the first
  // rising edge with pready high. The shadow registers follow at that edge,
  // and any write throws away the best count.
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'(idx * REG_STRIDE);
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_NORMAL_X:     plane_cfg.normal_x     = v[15:0];
      REG_NORMAL_Y:     plane_cfg.normal_y     = v[15:0];
      REG_NORMAL_Z:     plane_cfg.normal_z     = v[15:0];
      REG_PLANE_OFFSET: plane_cfg.plane_offset = v[31:0];
      REG_CENTER_XYZ:   plane_cfg.center_xyz   = v[47:0];
      REG_RADIUS:       plane_cfg.radius       = v[15:0];
      REG_THRESHOLD:    plane_cfg.threshold    = v[15:0];
      REG_UPDATE_EN:    plane_cfg.update_en    = v[0];
      default: ;
    endcase
    best_tally = '0;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Offers one point and returns at the rising edge of its transfer. The
  // prediction is made right there, long before the report can come out.
  // Valid stays high on return; the next call or settle() decides at the
  // following falling edge whether it drops.
  task automatic send_point(input point_t p, input bit fixed, input report_t want);
    report_t rep;
    bit      closes;
    @(negedge clk);
    if (!gapless && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 32);
    end
    if (burst_left != 0) burst_left--;
    point_x    = p.x;
    point_y    = p.y;
    point_z    = p.z;
    last_point = p.last;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
    closes = tally_point(p, rep);
    if (closes) awaited_reports.push_back(fixed ? want : rep);
  endtask

  // Stops offering points, waits for every owed report, then lets the core
  // run dry so that non-last points still in its pipeline are done too.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver: stretches of random length, each with its own stall pattern,
  // and a long hold-off whenever the main sequence asks for one.
  initial begin
    int stretch_left;
    int mode;
    stretch_left = 0;
    mode         = 0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (stretch_left == 0) begin
        mode         = $urandom_range(0, 3);
        stretch_left = $urandom_range(8, 80);
      end
      stretch_left--;
      case (mode)
        0:       out_stall = 1'b0;
        1:       out_stall = ($urandom_range(0, 3) == 0);
        2:       out_stall = ($urandom_range(0, 3) != 0);
        default: out_stall = ~out_stall;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  // Every report transfer is held against the oldest prediction.
  always @(posedge clk) begin : check_reports
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        flag_mismatch("report with none awaited", 64'd0, 64'(inlier_count));
      end else begin
        want = awaited_reports.pop_front();
        if (inlier_count !== want.inlier_count)
          flag_mismatch("inlier_count", 64'(want.inlier_count), 64'(inlier_count));
        if (best_count !== want.best_count)
          flag_mismatch("best_count", 64'(want.best_count), 64'(best_count));
        if (best_center !== want.best_center)
          flag_mismatch("best_center", 64'(want.best_center), 64'(best_center));
        if (best_changed !== want.best_changed)
          flag_mismatch("best_changed", 64'(want.best_changed), 64'(best_changed));
      end
    end
  end

  // Watchdog: the run is stuck when no transfer of any kind happens for too
  // long. The limit is far above the longest legal quiet spell, the receiver
  // hold-off.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    plan_step_t directed_plan[$];
    plan_step_t row;
    point_t     pt;
    int         sent, quota, phase, pass_len, span, axis, rad, thr, n_bits;
    int         nrm[3];
    int         cen[3];
    int         nv[3];
    int         q[3];
    longint     off;

    // Directed plan. Reports are typed in only where they are obvious: right
    // after reset the radius is zero, so the model is invalid and every pass
    // reports all zeros; the first valid pass of one central point is trivial.
    row       = point_row(0, 0, 0, 1'b1);
    row.fixed = 1'b1;
    row.want  = '0;
    directed_plan.push_back(row);
    directed_plan.push_back(point_row(32767, -32768, 32767, 1'b0));
    row       = point_row(-32768, 32767, -32768, 1'b1);
    row.fixed = 1'b1;
    row.want  = '0;
    directed_plan.push_back(row);
    // Widest possible model around the origin with the normal along z.
    directed_plan.push_back(write_row(REG_RADIUS, 64'd65535));
    directed_plan.push_back(write_row(REG_THRESHOLD, 64'd65535));
    row       = point_row(0, 0, 0, 1'b1);
    row.fixed = 1'b1;
    row.want  = '{inlier_count: 17'd1, best_count: 17'd1, best_center: '0,
                  best_changed: 1'b1};
    directed_plan.push_back(row);
    // Growing passes: the second one beats a nonzero best and takes the
    // center; a smaller pass after that leaves the record alone.
    directed_plan.push_back(write_row(REG_CENTER_XYZ, 64'(pack_center(100, -200, 300))));
    directed_plan.push_back(point_row(100, -200, 300, 1'b0));
    directed_plan.push_back(point_row(100, -200, 300, 1'b1));
    directed_plan.push_back(point_row(100, -200, 300, 1'b0));
    directed_plan.push_back(point_row(100, -200, 300, 1'b0));
    directed_plan.push_back(point_row(100, -200, 300, 1'b1));
    directed_plan.push_back(point_row(0, 0, 0, 1'b1));
    // Zero threshold: only points exactly on the plane count.
    directed_plan.push_back(write_row(REG_THRESHOLD, 64'd0));
    directed_plan.push_back(point_row(100, -200, 0, 1'b0));
    directed_plan.push_back(point_row(100, -200, 1, 1'b1));
    // Tracking off: a pass count never becomes the best.
    directed_plan.push_back(write_row(REG_UPDATE_EN, 64'd0));
    directed_plan.push_back(point_row(0, 0, 0, 1'b1));
    // Tiny radius: a single axis beyond the radius rejects the point, and a
    // point exactly on the sphere still counts.
    directed_plan.push_back(write_row(REG_UPDATE_EN, 64'd1));
    directed_plan.push_back(write_row(REG_RADIUS, 64'd3));
    directed_plan.push_back(write_row(REG_THRESHOLD, 64'd65535));
    directed_plan.push_back(write_row(REG_CENTER_XYZ, 64'd0));
    directed_plan.push_back(point_row(4, 0, 0, 1'b0));
    directed_plan.push_back(point_row(2, 2, 2, 1'b0));
    directed_plan.push_back(point_row(3, 0, 0, 1'b0));
    directed_plan.push_back(point_row(2, 2, 1, 1'b1));
    // Center in the far corner: the largest coordinate differences.
    directed_plan.push_back(write_row(REG_RADIUS, 64'd65535));
    directed_plan.push_back(write_row(REG_CENTER_XYZ, 64'(pack_center(32767, 32767, 32767))));
    directed_plan.push_back(point_row(-32768, 32767, 32767, 1'b0));
    directed_plan.push_back(point_row(-32768, -32768, 32767, 1'b1));
    // Extreme normals and offsets.
    directed_plan.push_back(write_row(REG_NORMAL_X, 64'(-16384)));
    directed_plan.push_back(write_row(REG_NORMAL_Z, 64'd0));
    directed_plan.push_back(write_row(REG_PLANE_OFFSET, -64'sd2147483648));
    directed_plan.push_back(write_row(REG_CENTER_XYZ, 64'd0));
    directed_plan.push_back(point_row(-32768, 0, 0, 1'b1));
    directed_plan.push_back(write_row(REG_NORMAL_Y, 64'd16384));
    directed_plan.push_back(write_row(REG_PLANE_OFFSET, 64'd2147483647));
    directed_plan.push_back(point_row(32767, -32768, 0, 1'b1));

    // Reset is applied once, at the start.
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_WRITE) begin
        settle();
        write_reg(directed_plan[i].idx, directed_plan[i].value);
      end else begin
        send_point(directed_plan[i].pt, directed_plan[i].fixed, directed_plan[i].want);
      end
    end

    // Random phases. Each one starts from an idle core and writes a random
    // choice of the plane registers; the plane mostly passes through the center
    // so that many points land inside. Phase two runs back to back against a
    // long receiver hold-off, so the input queue fills and the core stalls.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      axis = $urandom_range(0, 2);
      if ($urandom_range(0, 3) != 0) begin
        nrm       = '{0, 0, 0};
        nrm[axis] = $urandom_range(0, 1) ? 16384 : -16384;
      end else begin
        foreach (nrm[j]) nrm[j] = int'($urandom_range(32768)) - 16384;
      end
      foreach (cen[j])
        cen[j] = ($urandom_range(0, 9) < 7) ? int'($urandom_range(4000)) - 2000
                                            : int'($urandom_range(65535)) - 32768;
      off = -(longint'(nrm[0]) * cen[0] + longint'(nrm[1]) * cen[1] +
              longint'(nrm[2]) * cen[2]);
      if ($urandom_range(0, 9) == 0) off = longint'($signed($urandom()));
      n_bits = $urandom_range(0, 9);
      rad = (n_bits == 0) ? 0 : (n_bits == 1) ? 65535 : int'($urandom_range(1, 3000));
      n_bits = $urandom_range(0, 9);
      thr = (n_bits == 0) ? 0 : (n_bits == 1) ? 65535 : int'($urandom_range(0, 400));
      if ($urandom_range(0, 9) < 7) begin
        write_reg(REG_NORMAL_X, 64'(nrm[0]));
        write_reg(REG_NORMAL_Y, 64'(nrm[1]));
        write_reg(REG_NORMAL_Z, 64'(nrm[2]));
        write_reg(REG_PLANE_OFFSET, 64'(off));
        write_reg(REG_CENTER_XYZ, 64'(pack_center(cen[0], cen[1], cen[2])));
      end
      if ($urandom_range(0, 9) < 7) write_reg(REG_RADIUS, 64'(rad));
      if ($urandom_range(0, 9) < 7) write_reg(REG_THRESHOLD, 64'(thr));
      if ($urandom_range(0, 9) < 7) write_reg(REG_UPDATE_EN, 64'($urandom_range(0, 4) != 0));

      if (phase == 2) begin
        gapless = 1'b1;
        holds_asked++;
      end

      // Points are generated from the registers as they now stand.
      nv[0] = int'($signed(plane_cfg.normal_x));
      nv[1] = int'($signed(plane_cfg.normal_y));
      nv[2] = int'($signed(plane_cfg.normal_z));
      axis  = -1;
      foreach (nv[j])
        if ((nv[j] == 16384 || nv[j] == -16384) && nv[(j + 1) % 3] == 0 &&
            nv[(j + 2) % 3] == 0) axis = j;
      span = int'(plane_cfg.radius) + int'(plane_cfg.radius) / 4 + 2;
      if (span > 40000) span = 40000;
      cen[0] = int'($signed(plane_cfg.center_xyz[15:0]));
      cen[1] = int'($signed(plane_cfg.center_xyz[31:16]));
      cen[2] = int'($signed(plane_cfg.center_xyz[47:32]));
      thr    = int'(plane_cfg.threshold);

      quota = sent + 140;
      while (sent < quota) begin
        if (gapless) pass_len = $urandom_range(1, 4);
        else if ($urandom_range(0, 9) < 7) pass_len = $urandom_range(1, 12);
        else pass_len = $urandom_range(13, 40);
        for (int k = 0; k < pass_len; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            // Noise: any coordinate at all.
            pt.x = COORD_BITS'($urandom());
            pt.y = COORD_BITS'($urandom());
            pt.z = COORD_BITS'($urandom());
          end else begin
            // Near the center, a bit beyond the radius at most, and with an
            // axis normal also close to the plane.
            foreach (q[j]) q[j] = cen[j] + int'($urandom_range(2 * span)) - span;
            if (axis >= 0)
              q[axis] = int'(longint'($signed(plane_cfg.plane_offset)) / -nv[axis]) +
                        int'($urandom_range(2 * (thr + 2))) - (thr + 2);
            foreach (q[j]) q[j] = (q[j] > 32767) ? 32767 : (q[j] < -32768) ? -32768 : q[j];
            pt.x = COORD_BITS'(q[0]);
            pt.y = COORD_BITS'(q[1]);
            pt.z = COORD_BITS'(q[2]);
          end
          pt.last = (k == pass_len - 1);
          send_point(pt, 1'b0, '0);
          sent++;
        end
      end
      gapless = 1'b0;
      phase++;
    end

    // Drain the last reports and give the core time to show anything extra.
    settle();
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
